[src/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// Barometric sensor compensation package
// Widths, scaling constants, register indexes and sequencer states shared by
// the compensation block and its checker.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int FILTER_FRAC_BITS_DEF = 16;

  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int IDX_W   = 3;
  localparam int TEMP_W  = 16;
  localparam int PRESS_W = 23;

  localparam int MUL_W   = 25;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int T_W     = 21;
  localparam int OFFS_W  = 40;
  localparam int AUX_W   = 40;

  localparam int T_BASE        = 2000;
  localparam int TREF_SHIFT    = 8;
  localparam int TEMP_SHIFT    = 23;
  localparam int OFF_SHIFT     = 16;
  localparam int OFF_TC_SHIFT  = 7;
  localparam int SENS_SHIFT    = 15;
  localparam int SENS_TC_SHIFT = 8;
  localparam int T2_SHIFT      = 31;
  localparam int AUX_MUL_SHIFT = 2;
  localparam int OFF2_SHIFT    = 1;
  localparam int SENS2_SHIFT   = 2;

  localparam int P_SHIFT1   = 21;
  localparam int P_SHIFT2   = 15;
  localparam int SENS_SPLIT = 20;
  localparam int FS_SPLIT   = 24;

  localparam int ALPHA_W     = 16;
  localparam int ALPHA_ONE   = 65536;
  localparam int ROUND_HALF  = 32768;
  localparam int ROUND_SHIFT = 16;

  localparam int TEMP_MAX   = 32767;
  localparam int TEMP_MIN   = -32768;
  localparam int P_MAX      = 4194303;
  localparam int P_MIN      = -4194304;
  localparam int P_VALID_LO = 45000;
  localparam int P_VALID_HI = 120000;

  typedef enum logic [IDX_W-1:0] {
    REG_CAL_SENS,
    REG_CAL_OFFSET,
    REG_CAL_SENS_TC,
    REG_CAL_OFFSET_TC,
    REG_CAL_TREF,
    REG_CAL_TEMPSENS,
    REG_FILTER_ALPHA
  } bsc_reg_t;

  localparam int REG_COUNT = 7;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_MUL1,
    ST_T_MUL2,
    ST_T_MUL3,
    ST_T_MUL4,
    ST_T_MUL5,
    ST_T_MUL6,
    ST_T_FIN,
    ST_P_MUL1,
    ST_P_MUL2,
    ST_P_MUL3,
    ST_P_Q1,
    ST_P_Q2,
    ST_P_Q3,
    ST_P_SAT,
    ST_P_F1,
    ST_P_F2,
    ST_P_F3,
    ST_P_F4
  } bsc_state_t;

endpackage

[src/baro_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Second-order integer compensation of alternating temperature and pressure
// conversions, with a one-pole pressure filter, on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | request   | in_valid / in_ready  | in_raw_sample
//  out     | result    | out_valid / out_ready| kind, temperature, pressure,
//          |           |                      | filtered pressure, valid flag
//  cfg     | write     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
//  Each request runs as a series of passes through the single 25x25
//  multiplier and its accumulator. in_ready is high only while the
//  sequencer is idle.
//  The result sits in an output register; a stalled result holds the
//  sequencer in its last step, the next request waits behind it.
//  Reset is synchronous, active low, and clears all calibration and the sequencer state.
// ----------------------------------------------------------------------------
module baro_sensor_compensation #(
  parameter int FILTER_FRAC_BITS = bsc_pkg::FILTER_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bsc_pkg::RAW_W-1:0]            in_raw_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_sample_kind,
  output logic signed [bsc_pkg::TEMP_W-1:0]    out_temperature_centi,
  output logic signed [bsc_pkg::PRESS_W-1:0]   out_pressure_pa,
  output logic signed [bsc_pkg::PRESS_W-1:0]   out_filtered_pa,
  output logic                                 out_pressure_valid,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bsc_pkg::IDX_W-1:0]            cfg_index,
  input  logic [bsc_pkg::CAL_W-1:0]            cfg_wdata
);

  localparam int FS_W    = bsc_pkg::PRESS_W + FILTER_FRAC_BITS;
  localparam int FS_HI_W = FS_W - bsc_pkg::FS_SPLIT;
  localparam int SUM_W   = FS_W + bsc_pkg::ALPHA_W + 3;
  localparam int PP_W    = bsc_pkg::RAW_W + bsc_pkg::OFFS_W;
  localparam int ACC_W   = (SUM_W > PP_W) ? SUM_W : PP_W;

  localparam int MUL_W  = bsc_pkg::MUL_W;
  localparam int PROD_W = bsc_pkg::PROD_W;
  localparam int T_W    = bsc_pkg::T_W;
  localparam int OFFS_W = bsc_pkg::OFFS_W;
  localparam int AUX_W  = bsc_pkg::AUX_W;

  bsc_pkg::bsc_state_t state_r, state_nxt;

  logic [bsc_pkg::CAL_W-1:0] cal_r [bsc_pkg::REG_COUNT];
  logic [bsc_pkg::CAL_W-1:0] cal_nxt [bsc_pkg::REG_COUNT];

  logic                              expect_r, expect_nxt;
  logic [bsc_pkg::RAW_W-1:0]         raw_r, raw_nxt;
  logic signed [MUL_W-1:0]           dt_r, dt_nxt;
  logic signed [T_W-1:0]             t_r, t_nxt;
  logic                              cold_r, cold_nxt;
  logic signed [OFFS_W-1:0]          off_r, off_nxt;
  logic signed [OFFS_W-1:0]          sens_r, sens_nxt;
  logic [AUX_W-1:0]                  aux5_r, aux5_nxt;
  logic signed [ACC_W-1:0]           acc_r, acc_nxt;
  logic signed [PROD_W-1:0]          prod_r, prod_nxt;
  logic signed [FS_W-1:0]            fs_r, fs_nxt;
  logic signed [bsc_pkg::TEMP_W-1:0] last_temp_r, last_temp_nxt;
  logic signed [bsc_pkg::PRESS_W-1:0] last_press_r, last_press_nxt;
  logic                              last_valid_r, last_valid_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_kind_r, out_kind_nxt;
  logic signed [bsc_pkg::TEMP_W-1:0]  out_temp_r, out_temp_nxt;
  logic signed [bsc_pkg::PRESS_W-1:0] out_press_r, out_press_nxt;
  logic signed [bsc_pkg::PRESS_W-1:0] out_filt_r, out_filt_nxt;
  logic                               out_pvalid_r, out_pvalid_nxt;

  logic                               in_accept;
  logic                               out_free;
  logic signed [MUL_W-1:0]            mul_a, mul_b;
  logic signed [ACC_W-1:0]            prod_ext;
  logic signed [PROD_W-1:0]           bias_t, bias_o, bias_s;
  logic signed [PROD_W-1:0]           q_t, q_o, q_s;
  logic signed [ACC_W-1:0]            bias_p1, bias_p2;
  logic signed [ACC_W-1:0]            acc_q1, acc_q2;
  logic signed [ACC_W-1:0]            off_ext;
  logic signed [ACC_W-1:0]            round_sum;
  logic signed [FS_W-1:0]             fs_round;
  logic signed [MUL_W-1:0]            dt_abs;
  logic signed [T_W-1:0]              d_w;
  logic signed [bsc_pkg::TEMP_W-1:0]  t_sat;
  logic signed [bsc_pkg::PRESS_W-1:0] p_sat;
  logic                               p_in_range;
  logic [bsc_pkg::ALPHA_W:0]          weight;

  assign in_ready  = (state_r == bsc_pkg::ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign out_valid             = out_valid_r;
  assign out_sample_kind       = out_kind_r;
  assign out_temperature_centi = out_temp_r;
  assign out_pressure_pa       = out_press_r;
  assign out_filtered_pa       = out_filt_r;
  assign out_pressure_valid    = out_pvalid_r;

  // truncation toward zero: bias negative values before the arithmetic shift
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign bias_t   = prod_r[PROD_W-1] ? PROD_W'((1 << bsc_pkg::TEMP_SHIFT) - 1) : '0;
  assign bias_o   = prod_r[PROD_W-1] ? PROD_W'((1 << bsc_pkg::OFF_TC_SHIFT) - 1) : '0;
  assign bias_s   = prod_r[PROD_W-1] ? PROD_W'((1 << bsc_pkg::SENS_TC_SHIFT) - 1) : '0;
  assign q_t      = (prod_r + bias_t) >>> bsc_pkg::TEMP_SHIFT;
  assign q_o      = (prod_r + bias_o) >>> bsc_pkg::OFF_TC_SHIFT;
  assign q_s      = (prod_r + bias_s) >>> bsc_pkg::SENS_TC_SHIFT;
  assign bias_p1  = acc_r[ACC_W-1] ? ACC_W'((1 << bsc_pkg::P_SHIFT1) - 1) : '0;
  assign bias_p2  = acc_r[ACC_W-1] ? ACC_W'((1 << bsc_pkg::P_SHIFT2) - 1) : '0;
  assign acc_q1   = (acc_r + bias_p1) >>> bsc_pkg::P_SHIFT1;
  assign acc_q2   = (acc_r + bias_p2) >>> bsc_pkg::P_SHIFT2;
  assign off_ext  = {{(ACC_W-OFFS_W){off_r[OFFS_W-1]}}, off_r};

  assign round_sum = acc_r + ACC_W'(bsc_pkg::ROUND_HALF);
  assign fs_round  = round_sum[FS_W+bsc_pkg::ROUND_SHIFT-1:bsc_pkg::ROUND_SHIFT];

  assign dt_abs = dt_r[MUL_W-1] ? -dt_r : dt_r;
  assign d_w    = t_r - T_W'(bsc_pkg::T_BASE);
  assign weight = (bsc_pkg::ALPHA_W+1)'(bsc_pkg::ALPHA_ONE)
                  - {1'b0, cal_r[bsc_pkg::REG_FILTER_ALPHA]};

  assign p_in_range = (acc_r > ACC_W'(bsc_pkg::P_VALID_LO))
                      && (acc_r < ACC_W'(bsc_pkg::P_VALID_HI));

  always_comb begin
    if (t_r > T_W'(bsc_pkg::TEMP_MAX)) begin
      t_sat = bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MAX);
    end else if (t_r < T_W'(bsc_pkg::TEMP_MIN)) begin
      t_sat = bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MIN);
    end else begin
      t_sat = t_r[bsc_pkg::TEMP_W-1:0];
    end
  end

  always_comb begin
    if (acc_r > ACC_W'(bsc_pkg::P_MAX)) begin
      p_sat = bsc_pkg::PRESS_W'(bsc_pkg::P_MAX);
    end else if (acc_r < ACC_W'(bsc_pkg::P_MIN)) begin
      p_sat = bsc_pkg::PRESS_W'(bsc_pkg::P_MIN);
    end else begin
      p_sat = acc_r[bsc_pkg::PRESS_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < bsc_pkg::REG_COUNT; i++) begin
      cal_nxt[i] = cal_r[i];
      if (cfg_valid && cfg_index == bsc_pkg::IDX_W'(i)) begin
        cal_nxt[i] = cfg_wdata;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsc_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = expect_r ? bsc_pkg::ST_P_MUL1 : bsc_pkg::ST_T_MUL1;
        end
      end
      bsc_pkg::ST_T_MUL1: state_nxt = bsc_pkg::ST_T_MUL2;
      bsc_pkg::ST_T_MUL2: state_nxt = bsc_pkg::ST_T_MUL3;
      bsc_pkg::ST_T_MUL3: state_nxt = bsc_pkg::ST_T_MUL4;
      bsc_pkg::ST_T_MUL4: state_nxt = bsc_pkg::ST_T_MUL5;
      bsc_pkg::ST_T_MUL5: state_nxt = bsc_pkg::ST_T_MUL6;
      bsc_pkg::ST_T_MUL6: state_nxt = bsc_pkg::ST_T_FIN;
      bsc_pkg::ST_T_FIN: begin
        if (out_free) begin
          state_nxt = bsc_pkg::ST_IDLE;
        end
      end
      bsc_pkg::ST_P_MUL1: state_nxt = bsc_pkg::ST_P_MUL2;
      bsc_pkg::ST_P_MUL2: state_nxt = bsc_pkg::ST_P_MUL3;
      bsc_pkg::ST_P_MUL3: state_nxt = bsc_pkg::ST_P_Q1;
      bsc_pkg::ST_P_Q1:   state_nxt = bsc_pkg::ST_P_Q2;
      bsc_pkg::ST_P_Q2:   state_nxt = bsc_pkg::ST_P_Q3;
      bsc_pkg::ST_P_Q3:   state_nxt = bsc_pkg::ST_P_SAT;
      bsc_pkg::ST_P_SAT:  state_nxt = bsc_pkg::ST_P_F1;
      bsc_pkg::ST_P_F1:   state_nxt = bsc_pkg::ST_P_F2;
      bsc_pkg::ST_P_F2:   state_nxt = bsc_pkg::ST_P_F3;
      bsc_pkg::ST_P_F3:   state_nxt = bsc_pkg::ST_P_F4;
      bsc_pkg::ST_P_F4: begin
        if (out_free) begin
          state_nxt = bsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bsc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    expect_nxt     = expect_r;
    raw_nxt        = raw_r;
    dt_nxt         = dt_r;
    t_nxt          = t_r;
    cold_nxt       = cold_r;
    off_nxt        = off_r;
    sens_nxt       = sens_r;
    aux5_nxt       = aux5_r;
    acc_nxt        = acc_r;
    fs_nxt         = fs_r;
    last_temp_nxt  = last_temp_r;
    last_press_nxt = last_press_r;
    last_valid_nxt = last_valid_r;
    mul_a          = '0;
    mul_b          = '0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_temp_nxt   = out_temp_r;
    out_press_nxt  = out_press_r;
    out_filt_nxt   = out_filt_r;
    out_pvalid_nxt = out_pvalid_r;

    unique case (state_r)
      bsc_pkg::ST_IDLE: begin
        if (in_accept) begin
          raw_nxt = in_raw_sample;
          dt_nxt  = $signed(MUL_W'(in_raw_sample))
                    - $signed(MUL_W'(cal_r[bsc_pkg::REG_CAL_TREF]) << bsc_pkg::TREF_SHIFT);
        end
      end
      bsc_pkg::ST_T_MUL1: begin
        mul_a = dt_r;
        mul_b = MUL_W'(cal_r[bsc_pkg::REG_CAL_TEMPSENS]);
      end
      bsc_pkg::ST_T_MUL2: begin
        t_nxt    = q_t[T_W-1:0] + T_W'(bsc_pkg::T_BASE);
        cold_nxt = q_t[PROD_W-1];
        mul_a    = dt_r;
        mul_b    = MUL_W'(cal_r[bsc_pkg::REG_CAL_OFFSET_TC]);
      end
      bsc_pkg::ST_T_MUL3: begin
        off_nxt = (OFFS_W'(cal_r[bsc_pkg::REG_CAL_OFFSET]) << bsc_pkg::OFF_SHIFT)
                  + q_o[OFFS_W-1:0];
        mul_a   = dt_r;
        mul_b   = MUL_W'(cal_r[bsc_pkg::REG_CAL_SENS_TC]);
      end
      bsc_pkg::ST_T_MUL4: begin
        sens_nxt = (OFFS_W'(cal_r[bsc_pkg::REG_CAL_SENS]) << bsc_pkg::SENS_SHIFT)
                   + q_s[OFFS_W-1:0];
        mul_a    = dt_abs;
        mul_b    = dt_abs;
      end
      bsc_pkg::ST_T_MUL5: begin
        if (cold_r) begin
          t_nxt = t_r - T_W'(prod_r[PROD_W-2:bsc_pkg::T2_SHIFT]);
        end
        mul_a = MUL_W'(d_w);
        mul_b = MUL_W'(d_w);
      end
      bsc_pkg::ST_T_MUL6: begin
        aux5_nxt = prod_r[AUX_W-1:0] + (prod_r[AUX_W-1:0] << bsc_pkg::AUX_MUL_SHIFT);
      end
      bsc_pkg::ST_T_FIN: begin
        if (out_free) begin
          if (cold_r) begin
            off_nxt  = off_r - OFFS_W'(aux5_r >> bsc_pkg::OFF2_SHIFT);
            sens_nxt = sens_r - OFFS_W'(aux5_r >> bsc_pkg::SENS2_SHIFT);
          end
          last_temp_nxt  = t_sat;
          expect_nxt     = 1'b1;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = 1'b0;
          out_temp_nxt   = t_sat;
          out_press_nxt  = last_press_r;
          out_filt_nxt   = fs_r[FS_W-1:FILTER_FRAC_BITS];
          out_pvalid_nxt = last_valid_r;
        end
      end
      bsc_pkg::ST_P_MUL1: begin
        mul_a = MUL_W'(raw_r);
        mul_b = MUL_W'(sens_r[bsc_pkg::SENS_SPLIT-1:0]);
      end
      bsc_pkg::ST_P_MUL2: begin
        acc_nxt = prod_ext;
        mul_a   = MUL_W'(raw_r);
        mul_b   = MUL_W'($signed(sens_r[OFFS_W-1:bsc_pkg::SENS_SPLIT]));
      end
      bsc_pkg::ST_P_MUL3: begin
        acc_nxt = acc_r + (prod_ext <<< bsc_pkg::SENS_SPLIT);
      end
      bsc_pkg::ST_P_Q1: begin
        acc_nxt = acc_q1;
      end
      bsc_pkg::ST_P_Q2: begin
        acc_nxt = acc_r - off_ext;
      end
      bsc_pkg::ST_P_Q3: begin
        acc_nxt = acc_q2;
      end
      bsc_pkg::ST_P_SAT: begin
        last_press_nxt = p_sat;
        last_valid_nxt = p_in_range;
        mul_a          = MUL_W'(fs_r[bsc_pkg::FS_SPLIT-1:0]);
        mul_b          = MUL_W'(cal_r[bsc_pkg::REG_FILTER_ALPHA]);
      end
      bsc_pkg::ST_P_F1: begin
        acc_nxt = prod_ext;
        mul_a   = MUL_W'($signed(fs_r[FS_W-1:FS_W-FS_HI_W]));
        mul_b   = MUL_W'(cal_r[bsc_pkg::REG_FILTER_ALPHA]);
      end
      bsc_pkg::ST_P_F2: begin
        acc_nxt = acc_r + (prod_ext <<< bsc_pkg::FS_SPLIT);
        mul_a   = MUL_W'(last_press_r);
        mul_b   = MUL_W'(weight);
      end
      bsc_pkg::ST_P_F3: begin
        acc_nxt = acc_r + (prod_ext <<< FILTER_FRAC_BITS);
      end
      bsc_pkg::ST_P_F4: begin
        if (out_free) begin
          fs_nxt         = fs_round;
          expect_nxt     = 1'b0;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = 1'b1;
          out_temp_nxt   = last_temp_r;
          out_press_nxt  = last_press_r;
          out_filt_nxt   = fs_round[FS_W-1:FILTER_FRAC_BITS];
          out_pvalid_nxt = last_valid_r;
        end
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bsc_pkg::ST_IDLE;
      expect_r     <= 1'b0;
      off_r        <= '0;
      sens_r       <= '0;
      fs_r         <= '0;
      last_temp_r  <= '0;
      last_press_r <= '0;
      last_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < bsc_pkg::REG_COUNT; i++) begin
        cal_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      expect_r     <= expect_nxt;
      off_r        <= off_nxt;
      sens_r       <= sens_nxt;
      fs_r         <= fs_nxt;
      last_temp_r  <= last_temp_nxt;
      last_press_r <= last_press_nxt;
      last_valid_r <= last_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      for (int i = 0; i < bsc_pkg::REG_COUNT; i++) begin
        cal_r[i] <= cal_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    raw_r        <= raw_nxt;
    dt_r         <= dt_nxt;
    t_r          <= t_nxt;
    cold_r       <= cold_nxt;
    aux5_r       <= aux5_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= prod_nxt;
    out_kind_r   <= out_kind_nxt;
    out_temp_r   <= out_temp_nxt;
    out_press_r  <= out_press_nxt;
    out_filt_r   <= out_filt_nxt;
    out_pvalid_r <= out_pvalid_nxt;
  end

endmodule

[src/bsc_chk.sv]
// ----------------------------------------------------------------------------
// Barometric sensor compensation checker
// Port-level assertions on request sequencing, result order and flags.
// ----------------------------------------------------------------------------
module bsc_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 out_sample_kind,
  input logic signed [bsc_pkg::TEMP_W-1:0]    out_temperature_centi,
  input logic signed [bsc_pkg::PRESS_W-1:0]   out_pressure_pa,
  input logic signed [bsc_pkg::PRESS_W-1:0]   out_filtered_pa,
  input logic                                 out_pressure_valid
);

  logic exp_kind_r, exp_kind_nxt;

  assign exp_kind_nxt = (out_valid && out_ready) ? !exp_kind_r : exp_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_kind_r <= 1'b0;
    end else begin
      exp_kind_r <= exp_kind_nxt;
    end
  end

  // one request in flight: ready drops after every accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a previous one is still in work");

  // results alternate, temperature first
  a_kind_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> out_sample_kind == exp_kind_r)
    else $error("result kind out of order");

  // valid flag only for pressure strictly inside the window
  a_valid_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pressure_valid
    |-> out_pressure_pa > bsc_pkg::PRESS_W'(bsc_pkg::P_VALID_LO)
        && out_pressure_pa < bsc_pkg::PRESS_W'(bsc_pkg::P_VALID_HI))
    else $error("pressure flagged valid outside the window");

  // stalled result holds its filtered pressure and temperature
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready
    |=> out_valid && $stable(out_filtered_pa) && $stable(out_temperature_centi))
    else $error("stalled result changed");

endmodule

bind baro_sensor_compensation bsc_chk u_bsc_chk (.*);
